>>> sv/s224_pkg.sv
// Package for the SHA-224 stream hasher: the command struct to the compression
// core, the initial hash values, the round constants and the round functions.
// No dependencies.
`default_nettype none

package s224_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned TOTAL_W = 61;

   localparam logic [WORD_W-1:0] PAD_MARKER = 32'h8000_0000;
   localparam logic [2:0] BYTES_FULL = 3'd4;
   localparam logic [2:0] LAST_DIGEST_INDEX = 3'd6;
   localparam logic [3:0] LEN_HI_SLOT = 4'd14;
   localparam logic [3:0] LEN_LO_SLOT = 4'd15;
   localparam logic [5:0] LAST_ROUND = 6'd63;

   localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   localparam logic [WORD_W-1:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic              push;
      logic [WORD_W-1:0] word;
      logic              start;
      logic              reinit;
      logic [2:0]        rd_index;
   } s224_cmd_type;

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

`default_nettype wire

>>> sv/s224_if.sv
// Stream interfaces of the SHA-224 stream hasher: message words in, digest
// words out. Each carries valid, ready and its payload. No dependencies.
`default_nettype none

interface s224_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic        final_word;
   logic [2:0]  bytes_valid;

   modport source (output valid, message_word, final_word, bytes_valid, input ready);
   modport sink   (input valid, message_word, final_word, bytes_valid, output ready);
endinterface

interface s224_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  digest_index;
   logic        digest_done;

   modport source (output valid, digest_word, digest_index, digest_done, input ready);
   modport sink   (input valid, digest_word, digest_index, digest_done, output ready);
endinterface

`default_nettype wire

>>> sv/sha224_stream_hasher.sv
// SHA-224 stream hasher. Message words arrive big-endian on req_ch; a word
// flagged final_word carries 0 to 4 valid leading bytes (5 to 7 count as 4).
// Each 16-word block is compressed by one round unit at one round per cycle:
// after its sixteenth word no new word is taken until the compression is
// done. A final word adds one padding word per cycle while no compression
// runs, one or two compressions, and then the seven digest words leave on
// rsp_ch through an output register, one per cycle while the sink is ready.
// Afterwards the hash restarts from the initial values. Depends on s224_pkg,
// s224_if and s224_core.
`default_nettype none

module sha224_stream_hasher (
   input  wire logic  clock,
   input  wire logic  reset,
   s224_req_if.sink   req_ch,
   s224_rsp_if.source rsp_ch
);
   import s224_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_COMP = 2'd1;
   localparam logic [1:0] ST_PAD  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [3:0]         count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               padding_ff, padding_in;
   logic               marker_ff, marker_in;
   logic               len_hi_ff, len_hi_in;
   logic               final_blk_ff, final_blk_in;
   logic [2:0]         out_idx_ff, out_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic [2:0]         rsp_idx_ff, rsp_idx_in;
   logic               rsp_done_ff, rsp_done_in;

   s224_cmd_type      cmd;
   logic [WORD_W-1:0] core_word;
   logic              core_done;
   logic              accept;
   logic [2:0]        n_bytes;
   logic [WORD_W-1:0] keep_mask, tail_marker, final_first;

   s224_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .digest_word (core_word),
      .done        (core_done)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign n_bytes = (req_ch.bytes_valid > BYTES_FULL) ? BYTES_FULL : req_ch.bytes_valid;

   always_comb begin
      case (n_bytes)
         3'd0: begin
            keep_mask   = 32'h0000_0000;
            tail_marker = 32'h8000_0000;
         end
         3'd1: begin
            keep_mask   = 32'hff00_0000;
            tail_marker = 32'h0080_0000;
         end
         3'd2: begin
            keep_mask   = 32'hffff_0000;
            tail_marker = 32'h0000_8000;
         end
         3'd3: begin
            keep_mask   = 32'hffff_ff00;
            tail_marker = 32'h0000_0080;
         end
         default: begin
            keep_mask   = 32'hffff_ffff;
            tail_marker = 32'h0000_0000;
         end
      endcase
   end

   assign final_first = (req_ch.message_word & keep_mask) | tail_marker;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.digest_word  = rsp_word_ff;
   assign rsp_ch.digest_index = rsp_idx_ff;
   assign rsp_ch.digest_done  = rsp_done_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      padding_in   = padding_ff;
      marker_in    = marker_ff;
      len_hi_in    = len_hi_ff;
      final_blk_in = final_blk_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_done_in  = rsp_done_ff;

      cmd          = '0;
      cmd.rd_index = out_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.push = 1'b1;
               count_in = count_ff + 4'd1;
               if (req_ch.final_word) begin
                  cmd.word   = final_first;
                  total_in   = total_ff + TOTAL_W'(n_bytes);
                  padding_in = 1'b1;
                  // With all four bytes valid the marker needs a word of its own.
                  marker_in  = (n_bytes == BYTES_FULL);
               end else begin
                  cmd.word = req_ch.message_word;
                  total_in = total_ff + TOTAL_W'(BYTES_FULL);
               end
               if (count_ff == LEN_LO_SLOT) begin
                  cmd.start = 1'b1;
                  state_in  = ST_COMP;
               end else if (req_ch.final_word) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_COMP: begin
            if (core_done) begin
               if (final_blk_ff) begin
                  state_in   = ST_OUT;
                  out_idx_in = '0;
               end else if (padding_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            count_in = count_ff + 4'd1;
            if (marker_ff) begin
               cmd.word  = PAD_MARKER;
               marker_in = 1'b0;
            end else if (count_ff == LEN_HI_SLOT) begin
               cmd.word  = total_ff[TOTAL_W-1:TOTAL_W-WORD_W];
               len_hi_in = 1'b1;
            end else if (count_ff == LEN_LO_SLOT && len_hi_ff) begin
               cmd.word     = {total_ff[TOTAL_W-WORD_W-1:0], 3'b000};
               final_blk_in = 1'b1;
            end else begin
               cmd.word = '0;
            end
            if (count_ff == LEN_LO_SLOT) begin
               cmd.start = 1'b1;
               state_in  = ST_COMP;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = core_word;
               rsp_idx_in   = out_idx_ff;
               rsp_done_in  = (out_idx_ff == LAST_DIGEST_INDEX);
               out_idx_in   = out_idx_ff + 3'd1;
               if (out_idx_ff == LAST_DIGEST_INDEX) begin
                  // The last word sits in the output register, so the chain
                  // can restart while it waits for its transfer.
                  cmd.reinit   = 1'b1;
                  count_in     = '0;
                  total_in     = '0;
                  padding_in   = 1'b0;
                  marker_in    = 1'b0;
                  len_hi_in    = 1'b0;
                  final_blk_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         padding_ff   <= 1'b0;
         marker_ff    <= 1'b0;
         len_hi_ff    <= 1'b0;
         final_blk_ff <= 1'b0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         padding_ff   <= padding_in;
         marker_ff    <= marker_in;
         len_hi_ff    <= len_hi_in;
         final_blk_ff <= final_blk_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_done_ff <= rsp_done_in;
   end

endmodule

`default_nettype wire

>>> sv/s224_core.sv
// SHA-256 compression core shared by all blocks: a 16-word schedule window,
// the working variables and the chained hash, one round per cycle.
// Depends on s224_pkg.
`default_nettype none

module s224_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire s224_pkg::s224_cmd_type cmd,
   output logic [31:0]                digest_word,
   output logic                       done
);
   import s224_pkg::*;

   logic [WORD_W-1:0] w_ff [16];
   logic [WORD_W-1:0] w_in [16];
   logic [WORD_W-1:0] v_ff [8];
   logic [WORD_W-1:0] v_in [8];
   logic [WORD_W-1:0] chain_ff [8];
   logic [WORD_W-1:0] chain_in [8];
   logic [5:0]        round_ff, round_in;
   logic              run_ff, run_in;
   logic              add_ff, add_in;
   logic              done_ff, done_in;

   logic [WORD_W-1:0] t1, t2, w_next, ch_val, maj_val;

   assign ch_val  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj_val = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + ch_val + ROUND_K[round_ff] + w_ff[0];
   assign t2 = big_sigma0(v_ff[0]) + maj_val;
   assign w_next = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];

   assign digest_word = chain_ff[cmd.rd_index];
   assign done        = done_ff;

   always_comb begin
      w_in     = w_ff;
      v_in     = v_ff;
      chain_in = chain_ff;
      round_in = round_ff;
      run_in   = run_ff;
      add_in   = 1'b0;
      done_in  = 1'b0;

      // Message words enter the window from the top; during rounds the
      // window also slides, with the expanded word entering at the top.
      if (cmd.push) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = cmd.word;
      end

      if (run_ff) begin
         for (int i = 0; i < 15; i++) begin
            w_in[i] = w_ff[i+1];
         end
         w_in[15] = w_next;
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         round_in = round_ff + 6'd1;
         if (round_ff == LAST_ROUND) begin
            run_in = 1'b0;
            add_in = 1'b1;
         end
      end

      if (add_ff) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + v_ff[i];
         end
         done_in = 1'b1;
      end

      if (cmd.start) begin
         v_in     = chain_ff;
         run_in   = 1'b1;
         round_in = '0;
      end

      if (cmd.reinit) begin
         chain_in = INIT_HASH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         add_ff   <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
         chain_ff <= INIT_HASH;
      end else begin
         run_ff   <= run_in;
         add_ff   <= add_in;
         done_ff  <= done_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
   end

endmodule

`default_nettype wire

>>> sv/s224_checker.sv
// Port-level checks for the SHA-224 stream hasher and the bind that attaches
// them to it. Depends on sha224_stream_hasher and s224_if.
`default_nettype none

module s224_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_word,
   input wire logic [2:0]  rsp_index,
   input wire logic        rsp_done
);

   // A stalled digest word keeps its value until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) && $stable(rsp_index))
      else $error("digest word changed while stalled");

   // The done flag marks exactly the seventh digest word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_done == (rsp_index == 3'd6)))
      else $error("digest_done does not match digest_index");

   // No new message word is taken while earlier digest words are still due.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done |-> !req_ready)
      else $error("input ready during digest output");

   // Reset leaves no digest word pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("digest word valid after reset");

   // A word index only steps forward by one between transfers of one digest.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_done ##1 rsp_valid |-> rsp_index == $past(rsp_index) + 3'd1)
      else $error("digest words out of order");

endmodule

bind sha224_stream_hasher s224_checker u_s224_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_word  (rsp_ch.digest_word),
   .rsp_index (rsp_ch.digest_index),
   .rsp_done  (rsp_ch.digest_done)
);

`default_nettype wire
